FILE: design/cgcd_pkg.sv
// Shared constants, types and codes for the greedy CTC character decoder.
package cgcd_pkg;

  // Sizing
  localparam int unsigned MAX_CLASSES   = 64;
  localparam int unsigned MAX_POSITIONS = 256;
  localparam int unsigned STRING_BUFFER = 64;
  localparam int unsigned LABEL_DEPTH   = 64;

  // Field widths fixed by the interface
  localparam int unsigned SCORE_W = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LIDX_W  = 6;

  // Register widths
  localparam int unsigned NCLS_W   = 7;
  localparam int unsigned NPOS_W   = 9;
  localparam int unsigned LCNT_W   = 7;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned CAP_W    = 6;
  localparam int unsigned CFG_DW   = 9;
  localparam int unsigned CFG_IW   = 3;

  // Internal counter widths
  localparam int unsigned CLS_W  = $clog2(MAX_CLASSES);
  localparam int unsigned POS_W  = $clog2(MAX_POSITIONS);
  localparam int unsigned EMIT_W = $clog2(STRING_BUFFER);
  localparam int unsigned LADR_W = $clog2(LABEL_DEPTH);

  // Reset values
  localparam logic [NCLS_W-1:0] RST_CLASSES   = NCLS_W'(37);
  localparam logic [NPOS_W-1:0] RST_POSITIONS = NPOS_W'(32);
  localparam logic [LCNT_W-1:0] RST_LABELS    = '0;
  localparam logic [THR_W-1:0]  RST_THRESHOLD = THR_W'(255);
  localparam logic [CAP_W-1:0]  RST_MAX_CHARS = CAP_W'(63);

  // Clamp limits
  localparam logic [NCLS_W-1:0] NCLS_MAX = NCLS_W'(MAX_CLASSES);
  localparam logic [NPOS_W-1:0] NPOS_MAX = NPOS_W'(MAX_POSITIONS);
  localparam logic [CAP_W-1:0]  CAP_MAX  = CAP_W'(STRING_BUFFER - 1);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SCORE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CLASSES   = 3'd0,
    CFG_POSITIONS = 3'd1,
    CFG_LABELS    = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_MAX_CHARS = 3'd4
  } cfg_idx_e;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [NCLS_W-1:0] ncls;
    logic [NPOS_W-1:0] npos;
    logic [LCNT_W-1:0] label_count;
    logic [THR_W-1:0]  threshold;
    logic [CAP_W-1:0]  cap;
  } cfg_t;

  // Finished position handed to the emit stage
  typedef struct packed {
    logic [CLS_W-1:0]   best_class;
    logic [SCORE_W-1:0] best_score;
    logic               end_frame;
  } pos_t;

endpackage

FILE: design/cgcd_cfg_regs.sv
// Configuration registers with range clamping.
module cgcd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cgcd_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [cgcd_pkg::CFG_DW-1:0] cfg_wdata_i,
  output cgcd_pkg::cfg_t             cfg_o
);
  import cgcd_pkg::*;

  logic [NCLS_W-1:0] classes_q;
  logic [NPOS_W-1:0] positions_q;
  logic [LCNT_W-1:0] labels_q;
  logic [THR_W-1:0]  threshold_q;
  logic [CAP_W-1:0]  max_chars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      classes_q   <= RST_CLASSES;
      positions_q <= RST_POSITIONS;
      labels_q    <= RST_LABELS;
      threshold_q <= RST_THRESHOLD;
      max_chars_q <= RST_MAX_CHARS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CLASSES:   classes_q   <= cfg_wdata_i[NCLS_W-1:0];
        CFG_POSITIONS: positions_q <= cfg_wdata_i[NPOS_W-1:0];
        CFG_LABELS:    labels_q    <= cfg_wdata_i[LCNT_W-1:0];
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i[THR_W-1:0];
        CFG_MAX_CHARS: max_chars_q <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.ncls = classes_q;
    if (classes_q == '0)         cfg_o.ncls = NCLS_W'(1);
    else if (classes_q > NCLS_MAX) cfg_o.ncls = NCLS_MAX;

    cfg_o.npos = positions_q;
    if (positions_q == '0)         cfg_o.npos = NPOS_W'(1);
    else if (positions_q > NPOS_MAX) cfg_o.npos = NPOS_MAX;

    cfg_o.label_count = labels_q;
    cfg_o.threshold   = threshold_q;
    cfg_o.cap         = (max_chars_q > CAP_MAX) ? CAP_MAX : max_chars_q;
  end

endmodule

FILE: design/cgcd_argmax.sv
// Running first-maximum argmax with class and position counters.
module cgcd_argmax (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          score_acc_i,
  input  logic [cgcd_pkg::SCORE_W-1:0]  score_i,
  input  cgcd_pkg::cfg_t                cfg_i,
  output logic                          pos_done_o,
  output cgcd_pkg::pos_t                pos_o
);
  import cgcd_pkg::*;

  logic [SCORE_W-1:0] best_score_q, best_score_d;
  logic [CLS_W-1:0]   best_class_q, best_class_d;
  logic [CLS_W-1:0]   class_cnt_q;
  logic [POS_W-1:0]   pos_cnt_q;
  logic [NCLS_W-1:0]  class_nxt;
  logic [NPOS_W-1:0]  pos_nxt;
  logic               take;
  logic               pos_end;
  logic               frame_end;

  always_comb begin
    take         = (class_cnt_q == '0) || (score_i > best_score_q);
    best_score_d = take ? score_i : best_score_q;
    best_class_d = take ? class_cnt_q : best_class_q;
    class_nxt    = NCLS_W'(class_cnt_q) + NCLS_W'(1);
    pos_nxt      = NPOS_W'(pos_cnt_q) + NPOS_W'(1);
    pos_end      = class_nxt >= cfg_i.ncls;
    frame_end    = pos_nxt >= cfg_i.npos;

    pos_done_o       = score_acc_i && pos_end;
    pos_o.best_class = best_class_d;
    pos_o.best_score = best_score_d;
    pos_o.end_frame  = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_class_q <= '0;
      class_cnt_q  <= '0;
      pos_cnt_q    <= '0;
    end else if (score_acc_i) begin
      if (pos_end) begin
        best_score_q <= '0;
        best_class_q <= '0;
        class_cnt_q  <= '0;
        pos_cnt_q    <= frame_end ? '0 : pos_nxt[POS_W-1:0];
      end else begin
        best_score_q <= best_score_d;
        best_class_q <= best_class_d;
        class_cnt_q  <= class_nxt[CLS_W-1:0];
      end
    end
  end

endmodule

FILE: design/cgcd_label_mem.sv
// Label character table: one write port, registered read, per-entry valid bits.
module cgcd_label_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [cgcd_pkg::LADR_W-1:0]  waddr_i,
  input  logic [cgcd_pkg::CHAR_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [cgcd_pkg::LADR_W-1:0]  raddr_i,
  output logic [cgcd_pkg::CHAR_W-1:0]  rdata_o
);
  import cgcd_pkg::*;

  logic [CHAR_W-1:0]      mem_q [LABEL_DEPTH];
  logic [LABEL_DEPTH-1:0] vld_q;
  logic [CHAR_W-1:0]      rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Entries never loaded read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i)  vld_q[waddr_i] <= 1'b1;
      if (re_i)  rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: design/cgcd_emit.sv
// Emission check stage and output register.
module cgcd_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pos_done_i,
  input  cgcd_pkg::pos_t               pos_i,
  input  logic [cgcd_pkg::CHAR_W-1:0]  label_i,
  input  cgcd_pkg::cfg_t               cfg_i,
  output logic                         s2_free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cgcd_pkg::CHAR_W-1:0]  char_code_o,
  output logic                         char_valid_o,
  output logic                         last_o
);
  import cgcd_pkg::*;

  logic               s2_valid_q;
  pos_t               s2_q;
  logic [EMIT_W-1:0]  emitted_q;
  logic [CHAR_W-1:0]  last_char_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_code_q;
  logic               char_valid_q;
  logic               last_q;

  logic emit;
  logic has_res;
  logic out_free;
  logic s2_adv;

  always_comb begin
    emit = (CAP_W'(emitted_q) < cfg_i.cap) &&
           (s2_q.best_class != '0) &&
           (LCNT_W'(s2_q.best_class) < cfg_i.label_count) &&
           (label_i != '0) &&
           (s2_q.best_score > cfg_i.threshold) &&
           (label_i != last_char_q);
    has_res   = emit || s2_q.end_frame;
    out_free  = !out_valid_q || out_ready_i;
    s2_adv    = s2_valid_q && (!has_res || out_free);
    s2_free_o = !s2_valid_q || s2_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      emitted_q   <= '0;
      last_char_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free_o) s2_valid_q <= pos_done_i;
      if (s2_adv) begin
        if (s2_q.end_frame) begin
          emitted_q   <= '0;
          last_char_q <= '0;
        end else if (emit) begin
          emitted_q   <= emitted_q + EMIT_W'(1);
          last_char_q <= label_i;
        end
      end
      if (out_free) out_valid_q <= s2_valid_q && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_done_i && s2_free_o) s2_q <= pos_i;
    if (out_free && s2_valid_q && has_res) begin
      char_code_q  <= emit ? label_i : '0;
      char_valid_q <= emit;
      last_q       <= s2_q.end_frame;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_code_q;
  assign char_valid_o = char_valid_q;
  assign last_o       = last_q;

endmodule

FILE: design/ctc_greedy_char_decoder.sv
// Top level of the greedy CTC character decoder.
//
//  channel | signals                                          | dir | role
//  --------+--------------------------------------------------+-----+---------------------------
//  in      | in_valid_i/in_ready_o, command_i, label_index_i, | in  | label loads and class scores
//          | label_char_i, score_i                            |     |
//  out     | out_valid_o/out_ready_i, char_code_o,            | out | decoded characters, frame end
//          | char_valid_o, last_o                             |     |
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | in  | register writes, no wait
//
// One item is accepted per cycle while input ready is high. Each score item updates the
// running argmax in the cycle it is accepted; a position's last score launches a label
// table read at its accepting edge, the emit stage checks the winner in the next cycle,
// and its result is registered into the output register once that register is free.
// The label table reads empty straight out of reset (per-entry valid bits), so
// there is no clearing pass. When the output stalls, the emit stage holds one
// finished position and input ready drops only while that stage cannot drain.
module ctc_greedy_char_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [cgcd_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [cgcd_pkg::CFG_DW-1:0]  cfg_wdata_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [cgcd_pkg::LIDX_W-1:0]  label_index_i,
  input  logic [cgcd_pkg::CHAR_W-1:0]  label_char_i,
  input  logic [cgcd_pkg::SCORE_W-1:0] score_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cgcd_pkg::CHAR_W-1:0]  char_code_o,
  output logic                         char_valid_o,
  output logic                         last_o
);
  import cgcd_pkg::*;

  cfg_t              cfg;
  pos_t              pos;
  logic              pos_done;
  logic              s2_free;
  logic              in_acc;
  logic              load_acc;
  logic              score_acc;
  logic [CHAR_W-1:0] label;

  // The only thing that can hold up input is a full emit stage
  assign in_ready_o = s2_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (cmd_e'(command_i) == CMD_LOAD);
  assign score_acc  = in_acc && (cmd_e'(command_i) == CMD_SCORE);

  cgcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cgcd_argmax u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .score_acc_i (score_acc),
    .score_i     (score_i),
    .cfg_i       (cfg),
    .pos_done_o  (pos_done),
    .pos_o       (pos)
  );

  // Read address is the position's final winner; loads and reads never share a cycle
  cgcd_label_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (load_acc),
    .waddr_i (label_index_i),
    .wdata_i (label_char_i),
    .re_i    (pos_done),
    .raddr_i (pos.best_class),
    .rdata_o (label)
  );

  cgcd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pos_done_i   (pos_done),
    .pos_i        (pos),
    .label_i      (label),
    .cfg_i        (cfg),
    .s2_free_o    (s2_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_code_o  (char_code_o),
    .char_valid_o (char_valid_o),
    .last_o       (last_o)
  );

endmodule
